FILE: design/tls_pkg.sv
package tls_pkg;

    // Table size default and fixed field widths
    localparam int SLOTS_DEF = 64;
    localparam int DIV_NW    = 33;
    localparam int DIV_DW    = 32;
    localparam int DIV_STEPS = 33;

    localparam logic [30:0] ID_MAX    = 31'h7FFF_FFFF;
    localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
    localparam logic [31:0] RUN_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] AGING_RST = 16'd8000;

    // Command codes
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_LIFE    = 3'd1;
    localparam logic [2:0] CMD_SETQ    = 3'd2;
    localparam logic [2:0] CMD_SETP    = 3'd3;
    localparam logic [2:0] CMD_PALL    = 3'd4;
    localparam logic [2:0] CMD_SCHED   = 3'd5;
    localparam logic [2:0] CMD_RELEASE = 3'd6;

    // Life state codes
    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_LAST     = 3'd5;

    // Queue levels
    localparam logic [1:0] Q_LVL1 = 2'd1;
    localparam logic [1:0] Q_LVL2 = 2'd2;
    localparam logic [1:0] Q_LVL3 = 2'd3;

    // Configuration register indexes
    localparam logic CFG_AGING = 1'b0;
    localparam logic CFG_DEFQ  = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  slot;
        logic [30:0] target_pid;
        logic [15:0] new_value;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [5:0]  out_slot;
        logic [30:0] out_pid;
        logic [1:0]  served_queue;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_ALLOC, PH_LIFE, PH_FIND, PH_PALL, PH_Q1, PH_Q2, PH_Q3, PH_AGE
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   rd;
        logic   ev;
        logic   last;
        logic   div_go;
        logic   q3_cmp;
        logic   out_load;
        t_phase phase;
    } t_ctl;

    typedef struct packed {
        logic [2:0] command;
        logic       slot_ok;
        logic       pid_zero;
        logic       hit;
        logic       need_div;
        logic       div_done;
        logic       found;
    } t_sts;

endpackage

FILE: design/tls_div.sv
module tls_div import tls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic              take;

    // Shift in one dividend bit and try a subtract
    assign trial = {r_rem, r_quot[DIV_NW-1]};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload: remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_NW-2:0], take};
            r_rem  <= take ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: design/tls_ctrl.sv
module tls_ctrl import tls_pkg::*; #(
    parameter int TABLE_SLOTS = SLOTS_DEF,
    localparam int SW = $clog2(TABLE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  t_sts          i_st,
    output t_ctl          o_cmd,
    output logic [SW-1:0] o_idx
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_RD, S_EV, S_DIV, S_ENDP, S_FIN
    } t_state;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [SW-1:0] r_idx, n_idx;
    logic          r_out_vld, n_out_vld;
    logic          last;
    t_ctl          cmd;

    assign last = r_idx == SW'(TABLE_SLOTS - 1);

    // Sequence the table scans of each command
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        cmd       = '0;
        cmd.phase = r_phase;
        cmd.last  = last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_idx   = '0;
                n_state = S_RD;
                case (i_st.command)
                    CMD_ALLOC: n_phase = PH_ALLOC;
                    CMD_LIFE, CMD_RELEASE: begin
                        n_phase = PH_LIFE;
                        if (!i_st.slot_ok) n_state = S_FIN;
                    end
                    CMD_SETQ, CMD_SETP: begin
                        n_phase = PH_FIND;
                        if (i_st.pid_zero) n_state = S_FIN;
                    end
                    CMD_PALL:  n_phase = PH_PALL;
                    CMD_SCHED: n_phase = PH_Q1;
                    default:   n_state = S_FIN;
                endcase
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                cmd.ev = 1'b1;
                if (r_phase == PH_Q3 && i_st.need_div) begin
                    cmd.div_go = 1'b1;
                    n_state    = S_DIV;
                end else if (i_st.hit || last || r_phase == PH_LIFE) begin
                    n_state = S_ENDP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    cmd.q3_cmp = 1'b1;
                    if (last) begin
                        n_state = S_ENDP;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_ENDP: begin
                n_idx   = '0;
                n_state = S_RD;
                case (r_phase)
                    PH_Q1: n_phase = i_st.found ? PH_AGE : PH_Q2;
                    PH_Q2: n_phase = i_st.found ? PH_AGE : PH_Q3;
                    PH_Q3: begin
                        n_phase = PH_AGE;
                        if (!i_st.found) n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_load) n_out_vld = 1'b1;
        else if (!i_out_stall) n_out_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_ALLOC;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;
    assign o_idx       = r_idx;

endmodule

FILE: design/tls_dp.sv
module tls_dp import tls_pkg::*; #(
    parameter int TABLE_SLOTS = SLOTS_DEF,
    localparam int SW = $clog2(TABLE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in_item      i_in_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  t_ctl          i_cmd,
    input  logic [SW-1:0] i_idx,
    output t_sts          o_st,
    output t_out_item     o_out_data
);

    typedef struct packed {
        logic [2:0]  life;
        logic [30:0] id;
        logic [1:0]  queue;
        logic [31:0] arrival;
        logic [31:0] run;
        logic [15:0] prio;
        logic [15:0] wait_cnt;
    } t_row;

    localparam logic [SW:0] N_EXT = (SW + 1)'(TABLE_SLOTS);

    // Task table and its read port
    t_row             r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_vld;
    t_row             r_rd_row;
    logic             r_rd_vld;
    logic [SW-1:0]    r_addr;

    t_in_item         r_item, n_item;
    logic [15:0]      r_aging;
    logic [1:0]       r_defq;
    logic [SW-1:0]    r_rr, n_rr;
    logic [30:0]      r_next_id, n_next_id;
    logic [SW-1:0]    r_best, n_best;
    logic             r_found, n_found;
    logic [31:0]      r_best_arr, n_best_arr;
    logic [DIV_NW-1:0] r_best_score, n_best_score;
    logic [1:0]       r_served, n_served;
    t_out_item        r_res, n_res;
    t_out_item        r_out;

    t_row             e;
    t_row             wr_row;
    logic             wr_en;
    logic             hit;
    logic [SW:0]      rot_sum;
    logic [SW-1:0]    rot_addr;
    logic [SW-1:0]    rd_addr;
    logic [31:0]      div_den;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_NW-1:0] quot;
    logic             div_done;
    logic [DIV_NW:0]  score_sum;
    logic [DIV_NW-1:0] score;
    logic [15:0]      w;

    // Rotated address for the round-robin scan
    assign rot_sum  = {1'b0, i_idx} + {1'b0, r_rr};
    assign rot_addr = (rot_sum >= N_EXT) ? SW'(rot_sum - N_EXT) : SW'(rot_sum);

    always_comb begin
        case (i_cmd.phase)
            PH_Q1:   rd_addr = rot_addr;
            PH_LIFE: rd_addr = SW'(r_item.slot);
            default: rd_addr = i_idx;
        endcase
    end

    // Entries never written read as the reset value
    assign e = r_rd_vld ? r_rd_row : '0;

    // Queue-3 score: (((now-arrival)+run)/run + priority)/2
    assign div_den   = (e.run == '0) ? 32'd1 : e.run;
    assign div_num   = {1'b0, r_item.now - e.arrival} + {1'b0, e.run};
    assign score_sum = {1'b0, quot} + (DIV_NW + 1)'(r_rd_row.prio);
    assign score     = score_sum[DIV_NW:1];

    tls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Evaluate the addressed table entry for the current phase
    always_comb begin
        n_item       = r_item;
        n_rr         = r_rr;
        n_next_id    = r_next_id;
        n_best       = r_best;
        n_found      = r_found;
        n_best_arr   = r_best_arr;
        n_best_score = r_best_score;
        n_served     = r_served;
        n_res        = r_res;
        wr_en        = 1'b0;
        wr_row       = e;
        hit          = 1'b0;
        w            = e.wait_cnt;
        if (i_cmd.load) begin
            n_item   = i_in_data;
            n_res    = '0;
            n_found  = 1'b0;
            n_served = '0;
        end
        if (i_cmd.ev) begin
            case (i_cmd.phase)
                PH_ALLOC: begin
                    if (e.life == ST_UNUSED) begin
                        hit             = 1'b1;
                        wr_en           = 1'b1;
                        wr_row.life     = ST_EMBRYO;
                        wr_row.id       = r_next_id;
                        wr_row.queue    = r_defq;
                        wr_row.arrival  = r_item.now;
                        wr_row.run      = 32'd1;
                        wr_row.prio     = '0;
                        wr_row.wait_cnt = '0;
                        n_res.ok        = 1'b1;
                        n_res.out_slot  = 6'(r_addr);
                        n_res.out_pid   = r_next_id;
                        if (r_next_id != ID_MAX) n_next_id = r_next_id + 1'b1;
                    end
                end
                PH_LIFE: begin
                    if (e.life != ST_UNUSED) begin
                        n_res.out_slot = 6'(r_addr);
                        n_res.out_pid  = e.id;
                        if (r_item.command == CMD_RELEASE ||
                            r_item.new_value == 16'(ST_UNUSED)) begin
                            wr_en       = 1'b1;
                            wr_row.life = ST_UNUSED;
                            wr_row.id   = '0;
                            n_res.ok    = 1'b1;
                        end else if (r_item.new_value <= 16'(ST_LAST)) begin
                            wr_en       = 1'b1;
                            wr_row.life = 3'(r_item.new_value);
                            n_res.ok    = 1'b1;
                        end
                    end
                end
                PH_FIND: begin
                    if (e.id == r_item.target_pid) begin
                        hit            = 1'b1;
                        n_res.out_slot = 6'(r_addr);
                        n_res.out_pid  = e.id;
                        if (r_item.command == CMD_SETP) begin
                            wr_en       = 1'b1;
                            wr_row.prio = r_item.new_value;
                            n_res.ok    = 1'b1;
                        end else if (r_item.new_value >= 16'(Q_LVL1) &&
                                     r_item.new_value <= 16'(Q_LVL3)) begin
                            wr_en        = 1'b1;
                            wr_row.queue = 2'(r_item.new_value);
                            n_res.ok     = 1'b1;
                        end
                    end
                end
                PH_PALL: begin
                    if (e.id != '0) begin
                        wr_en       = 1'b1;
                        wr_row.prio = r_item.new_value;
                        n_res.ok    = 1'b1;
                    end
                end
                PH_Q1: begin
                    if (e.life == ST_RUNNABLE && e.queue == Q_LVL1) begin
                        hit      = 1'b1;
                        n_best   = r_addr;
                        n_found  = 1'b1;
                        n_served = Q_LVL1;
                        n_rr     = (r_addr == SW'(TABLE_SLOTS - 1)) ? '0 : r_addr + 1'b1;
                    end else if (i_cmd.last) begin
                        n_rr = '0;
                    end
                end
                PH_Q2: begin
                    if (e.life == ST_RUNNABLE && e.queue == Q_LVL2 &&
                        (!r_found || e.arrival >= r_best_arr)) begin
                        n_best     = r_addr;
                        n_best_arr = e.arrival;
                        n_found    = 1'b1;
                        n_served   = Q_LVL2;
                    end
                end
                PH_AGE: begin
                    if (e.id != '0) begin
                        wr_en = 1'b1;
                        if (e.life == ST_RUNNABLE && w != WAIT_MAX) w = w + 1'b1;
                        if (w > r_aging && e.queue > Q_LVL1) begin
                            wr_row.queue = e.queue - 1'b1;
                            w            = '0;
                        end
                        if (r_addr == r_best) begin
                            if (e.run != RUN_MAX) wr_row.run = e.run + 1'b1;
                            w                  = '0;
                            n_res.ok           = 1'b1;
                            n_res.out_slot     = 6'(r_addr);
                            n_res.out_pid      = e.id;
                            n_res.served_queue = r_served;
                        end
                        wr_row.wait_cnt = w;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.q3_cmp && (!r_found || score > r_best_score)) begin
            n_best       = r_addr;
            n_best_score = score;
            n_found      = 1'b1;
            n_served     = Q_LVL3;
        end
    end

    // Table read and write ports
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_addr] <= wr_row;
        if (i_cmd.rd) begin
            r_rd_row <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
            r_addr   <= rd_addr;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rr      <= '0;
            r_next_id <= 31'd1;
            r_found   <= 1'b0;
            r_aging   <= AGING_RST;
            r_defq    <= Q_LVL2;
        end else begin
            if (wr_en) r_vld[r_addr] <= 1'b1;
            r_rr      <= n_rr;
            r_next_id <= n_next_id;
            r_found   <= n_found;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AGING: r_aging <= i_cfg_data;
                    CFG_DEFQ:  r_defq  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_best       <= n_best;
        r_best_arr   <= n_best_arr;
        r_best_score <= n_best_score;
        r_served     <= n_served;
        r_res        <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
    end

    assign o_st.command  = r_item.command;
    assign o_st.slot_ok  = int'(r_item.slot) < TABLE_SLOTS;
    assign o_st.pid_zero = r_item.target_pid == '0;
    assign o_st.hit      = hit;
    assign o_st.need_div = e.life == ST_RUNNABLE && e.queue == Q_LVL3;
    assign o_st.div_done = div_done;
    assign o_st.found    = r_found;
    assign o_out_data    = r_out;

endmodule

FILE: design/three_level_task_scheduler.sv
// Channel  Valid        Stall         Payload
// in       i_in_valid   o_in_stall    i_in_data  (t_in_item)
// out      o_out_valid  i_out_stall   o_out_data (t_out_item)
// cfg      i_cfg_we     -             i_cfg_idx, i_cfg_data
//
// One transaction at a time; each table entry is first addressed, then evaluated
// and written back, through the single-port task table.
// Schedule scans the table for each queue level in turn until a task is found, then
// once more to age; the restoring divider runs for each runnable queue-3 task.
// Set life state and release read a single entry; other table commands scan the table.
// Synchronous active-low reset; no clearing pass, per-slot valid bits.
// A stalled result is held while the next transaction is accepted.
module three_level_task_scheduler import tls_pkg::*; #(
    parameter int TABLE_SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int SW = $clog2(TABLE_SLOTS);

    t_ctl          cmd;
    t_sts          st;
    logic [SW-1:0] idx;

    tls_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    tls_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .o_st       (st),
        .o_out_data (o_out_data)
    );

endmodule

FILE: design/tls_chk.sv
module tls_chk import tls_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Busy after taking a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // A served queue implies a pick
    a_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.served_queue != 2'd0 |-> o_out_data.ok)
        else $error("served queue without pick");

    // No result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind three_level_task_scheduler tls_chk u_chk (.*);

FILE: sim/three_level_task_scheduler_test.sv
`timescale 1ns / 100ps

module three_level_task_scheduler_test;
    import tls_pkg::*;

    localparam int           N        = 64;
    localparam logic [2:0]   CMD_NONE = 3'd7;
    localparam longint       LIMIT    = 4000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic      i_cfg_idx;
    logic [15:0] i_cfg_data;

    three_level_task_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the task table
    logic [2:0]  sh_life [N];
    logic [30:0] sh_pid  [N];
    logic [1:0]  sh_lvl  [N];
    logic [31:0] sh_arr  [N];
    logic [31:0] sh_runs [N];
    logic [15:0] sh_prio [N];
    logic [15:0] sh_wait [N];
    logic [5:0]  rr_ptr;
    logic [30:0] id_next;
    logic [15:0] lim_aging;
    logic [1:0]  q_default;

    t_out_item   pending_results[$];
    int          errors;
    longint      cycles;
    int          send_idle;
    int          recv_idle;
    bit          hold_req;
    bit          hold_taken;
    int          hold_left;
    logic [31:0] tick;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_row;

    t_row rows[$];

    // Clock and timeout
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("three_level_task_scheduler_test: errors");
            $finish;
        end
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int pick_task(logic [31:0] now, output logic [1:0] served);
        int               best;
        int               idx;
        longint unsigned  best_score;
        longint unsigned  sc;
        longint unsigned  div;
        best       = -1;
        best_score = 0;
        served     = 2'd0;
        // Round robin over queue one
        for (int i = 0; i < N; i++) begin
            idx = (i + rr_ptr) % N;
            if (sh_life[idx] == ST_RUNNABLE && sh_lvl[idx] == Q_LVL1) begin
                rr_ptr = 6'((idx + 1) % N);
                served = Q_LVL1;
                return idx;
            end
        end
        rr_ptr = '0;
        // Latest arrival in queue two, last of equals
        for (int i = 0; i < N; i++)
            if (sh_life[i] == ST_RUNNABLE && sh_lvl[i] == Q_LVL2 &&
                (best < 0 || sh_arr[i] >= sh_arr[best]))
                best = i;
        if (best >= 0) begin
            served = Q_LVL2;
            return best;
        end
        // Response ratio in queue three, first of equals
        for (int i = 0; i < N; i++) begin
            if (sh_life[i] == ST_RUNNABLE && sh_lvl[i] == Q_LVL3) begin
                div = (sh_runs[i] != 0) ? longint'(sh_runs[i]) : 1;
                sc  = (longint'(32'(now - sh_arr[i])) + longint'(sh_runs[i])) / div;
                sc  = (sc + longint'(sh_prio[i])) / 2;
                if (best < 0 || sc > best_score) begin
                    best       = i;
                    best_score = sc;
                end
            end
        end
        if (best >= 0)
            served = Q_LVL3;
        return best;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item   r;
        int          s;
        logic [1:0]  q;
        r = '0;
        case (it.command)
            CMD_ALLOC: begin
                for (int i = 0; i < N; i++) begin
                    if (sh_life[i] == ST_UNUSED) begin
                        sh_life[i] = ST_EMBRYO;
                        sh_pid[i]  = id_next;
                        if (id_next < ID_MAX)
                            id_next++;
                        sh_lvl[i]  = q_default;
                        sh_arr[i]  = it.now;
                        sh_runs[i] = 1;
                        sh_prio[i] = 0;
                        sh_wait[i] = 0;
                        r.ok = 1'b1; r.out_slot = 6'(i); r.out_pid = sh_pid[i];
                        break;
                    end
                end
            end
            CMD_LIFE, CMD_RELEASE: begin
                if (sh_life[it.slot] != ST_UNUSED) begin
                    r.out_slot = it.slot;
                    r.out_pid  = sh_pid[it.slot];
                    if (it.command == CMD_RELEASE || it.new_value == 16'(ST_UNUSED)) begin
                        sh_life[it.slot] = ST_UNUSED;
                        sh_pid[it.slot]  = '0;
                        r.ok = 1'b1;
                    end else if (it.new_value <= 16'(ST_LAST)) begin
                        sh_life[it.slot] = it.new_value[2:0];
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_SETQ, CMD_SETP: begin
                s = -1;
                if (it.target_pid != 0)
                    for (int i = 0; i < N; i++)
                        if (s < 0 && sh_pid[i] == it.target_pid)
                            s = i;
                if (s >= 0) begin
                    r.out_slot = 6'(s);
                    r.out_pid  = sh_pid[s];
                    if (it.command == CMD_SETP) begin
                        sh_prio[s] = it.new_value;
                        r.ok = 1'b1;
                    end else if (it.new_value >= 1 && it.new_value <= 3) begin
                        sh_lvl[s] = it.new_value[1:0];
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_PALL: begin
                for (int i = 0; i < N; i++)
                    if (sh_pid[i] != 0) begin
                        sh_prio[i] = it.new_value;
                        r.ok = 1'b1;
                    end
            end
            CMD_SCHED: begin
                s = pick_task(it.now, q);
                if (s >= 0) begin
                    if (sh_runs[s] != RUN_MAX)
                        sh_runs[s]++;
                    // Age every live task
                    for (int i = 0; i < N; i++) begin
                        if (sh_pid[i] != 0) begin
                            if (sh_life[i] == ST_RUNNABLE && sh_wait[i] != WAIT_MAX)
                                sh_wait[i]++;
                            if (sh_wait[i] > lim_aging && sh_lvl[i] > Q_LVL1) begin
                                sh_lvl[i]--;
                                sh_wait[i] = 0;
                            end
                        end
                    end
                    sh_wait[s] = 0;
                    r.ok = 1'b1; r.out_slot = 6'(s); r.out_pid = sh_pid[s];
                    r.served_queue = q;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item random_cmd(int alloc_pct);
        t_in_item it;
        int       s;
        int       r;
        it.command    = CMD_NONE;
        it.slot       = 6'($urandom);
        it.target_pid = 31'($urandom);
        it.new_value  = 16'($urandom);
        tick          = tick + $urandom_range(0, 60);
        it.now        = ($urandom_range(0, 19) == 0) ? 32'($urandom) : tick;
        // Aim mostly at a live slot
        s = $urandom_range(0, N - 1);
        for (int k = 0; k < 12 && sh_pid[s] == 0; k++)
            s = $urandom_range(0, N - 1);
        if ($urandom_range(0, 9) != 0) begin
            it.slot = 6'(s);
            it.target_pid = sh_pid[s];
        end
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            it.command = CMD_ALLOC;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                it.command = CMD_LIFE;
                if ($urandom_range(0, 9) < 7)
                    it.new_value = 16'(ST_RUNNABLE);
                else if ($urandom_range(0, 1))
                    it.new_value = 16'($urandom_range(0, 7));
            end else if (r < 40) begin
                it.command = CMD_SETQ;
                if ($urandom_range(0, 9) != 0)
                    it.new_value = 16'($urandom_range(1, 3));
            end else if (r < 50) begin
                it.command = CMD_SETP;
                if ($urandom_range(0, 1))
                    it.new_value = 16'($urandom_range(0, 40));
            end else if (r < 55) begin
                it.command = CMD_PALL;
            end else if (r < 90) begin
                it.command = CMD_SCHED;
            end else if (r < 97) begin
                it.command = CMD_RELEASE;
            end
        end
        return it;
    endfunction

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send(t_in_item it, bit typed, t_out_item res);
        t_out_item p;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        p = predict_result(it);
        pending_results.push_back(typed ? res : p);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_AGING)
            lim_aging = val;
        else
            q_default = val[1:0];
        @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [2:0] c, logic [5:0] sl, logic [30:0] pid,
                                logic [15:0] v, logic [31:0] now, bit typed,
                                logic ok, logic [5:0] os, logic [30:0] op, logic [1:0] sq);
        t_row w;
        w.item = '{command: c, slot: sl, target_pid: pid, new_value: v, now: now};
        w.typed = typed;
        w.res = '{ok: ok, out_slot: os, out_pid: op, served_queue: sq};
        return w;
    endfunction

    // Check each result against the oldest expectation, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_out_data, 0);
            end else begin
                t_out_item w;
                w = pending_results.pop_front();
                if (o_out_data.ok !== w.ok)
                    report("ok", o_out_data.ok, w.ok);
                if (o_out_data.out_slot !== w.out_slot)
                    report("out_slot", o_out_data.out_slot, w.out_slot);
                if (o_out_data.out_pid !== w.out_pid)
                    report("out_pid", o_out_data.out_pid, w.out_pid);
                if (o_out_data.served_queue !== w.served_queue)
                    report("served_queue", o_out_data.served_queue, w.served_queue);
            end
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 2000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    initial begin
        int alloc_pct;
        i_clk = 1'b0; i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0;
        i_out_stall = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_AGING; i_cfg_data = '0;
        errors = 0; cycles = 0; hold_req = 0; hold_taken = 0; hold_left = 0;
        send_idle = 17; recv_idle = 64; tick = 32'd5000;
        for (int i = 0; i < N; i++) begin
            sh_life[i] = '0; sh_pid[i] = '0; sh_lvl[i] = '0; sh_arr[i] = '0;
            sh_runs[i] = '0; sh_prio[i] = '0; sh_wait[i] = '0;
        end
        rr_ptr = '0; id_next = 31'd1; lim_aging = AGING_RST; q_default = Q_LVL2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, error codes, each queue level
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(CMD_ALLOC, 0, 0, 0, 100, 1, 1, 0, 1, 0));
        rows.push_back(mk(CMD_ALLOC, 63, ID_MAX, 16'hFFFF, 200, 1, 1, 1, 2, 0));
        rows.push_back(mk(CMD_ALLOC, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 2, 3, 0));
        rows.push_back(mk(CMD_LIFE, 0, 0, 3, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(CMD_LIFE, 1, 0, 3, 0, 1, 1, 1, 2, 0));
        rows.push_back(mk(CMD_LIFE, 2, 0, 7, 0, 1, 0, 2, 3, 0));
        rows.push_back(mk(CMD_LIFE, 63, 0, 3, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SETQ, 0, 1, 1, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(CMD_SETQ, 0, 2, 0, 0, 1, 0, 1, 2, 0));
        rows.push_back(mk(CMD_SETQ, 0, 0, 2, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SETQ, 0, ID_MAX, 3, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SETP, 0, 2, 16'hFFFF, 0, 1, 1, 1, 2, 0));
        rows.push_back(mk(CMD_PALL, 0, 0, 5, 0, 1, 1, 0, 0, 0));
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 1000, 1, 1, 0, 1, Q_LVL1));
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 1001, 1, 1, 0, 1, Q_LVL1));
        rows.push_back(mk(CMD_SETQ, 0, 1, 3, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 1002, 1, 1, 1, 2, Q_LVL2));
        rows.push_back(mk(CMD_SETQ, 0, 2, 3, 0, 1, 1, 1, 2, 0));
        rows.push_back(mk(CMD_LIFE, 2, 0, 3, 0, 1, 1, 2, 3, 0));
        rows.push_back(mk(CMD_SETQ, 0, 3, 3, 0, 1, 1, 2, 3, 0));
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SCHED, 0, 0, 0, 32'h0000_0000, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_RELEASE, 1, 0, 0, 0, 1, 1, 1, 2, 0));
        rows.push_back(mk(CMD_LIFE, 0, 0, 0, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(CMD_NONE, 6'h3F, ID_MAX, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
        rows.push_back(mk(CMD_RELEASE, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        foreach (rows[k])
            send(rows[k].item, rows[k].typed, rows[k].res);

        // Random phases, each under its own configuration and one of three idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin write_cfg(CFG_AGING, AGING_RST); write_cfg(CFG_DEFQ, 16'(Q_LVL2)); end
                1: begin write_cfg(CFG_AGING, 16'd0);     write_cfg(CFG_DEFQ, 16'(Q_LVL1)); end
                2: begin write_cfg(CFG_AGING, 16'hFFFF);  write_cfg(CFG_DEFQ, 16'(Q_LVL3)); end
                default: begin write_cfg(CFG_AGING, 16'd3); write_cfg(CFG_DEFQ, 16'd0); end
            endcase
            send_idle = (ph < 2) ? 17 : (ph == 2) ? 64 : 0;
            recv_idle = (ph < 2) ? 64 : (ph == 2) ? 17 : 0;
            alloc_pct = (ph == 1) ? 55 : 22;
            for (int k = 0; k < 61; k++) begin
                // Long receiver hold-off early in the first phase
                if (ph == 0 && k == 5)
                    hold_req = 1'b1;
                send(random_cmd(alloc_pct), 0, '0);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("three_level_task_scheduler_test: clean");
        end else begin
            $display("three_level_task_scheduler_test: errors");
        end
        $finish;
    end

endmodule
